[design/uic_pkg.sv]
// Shared types and constants for the unique tag ID collector.
package uic_pkg;

   localparam int TAG_W      = 32;
   localparam int OUTCOME_W  = 3;
   localparam int SLOT_W     = 6;
   localparam int COUNT_W    = 7;
   localparam int RSP_PAD_W  = 3;
   localparam int RSP_DATA_W = SLOT_W + COUNT_W + TAG_W + RSP_PAD_W;
   localparam int CSR_IDX_W  = 1;

   localparam logic [TAG_W-1:0] MARKER_RESET = 32'hBB01_FF00;
   localparam logic             FILTER_RESET = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FILTER_EN = 1'b0,
      CSR_MARKER_ID = 1'b1
   } csr_index_type;

   typedef enum logic [OUTCOME_W-1:0] {
      OC_ADDED     = 3'd0,
      OC_DUPLICATE = 3'd1,
      OC_INVALID   = 3'd2,
      OC_FULL      = 3'd3,
      OC_CLEARED   = 3'd4
   } outcome_type;

   typedef enum logic [1:0] {
      CMD_NONE   = 2'd0,
      CMD_LOAD   = 2'd1,
      CMD_SCAN   = 2'd2,
      CMD_FINISH = 2'd3
   } cmd_type;

   typedef struct packed {
      logic skip_scan;
      logic hit;
      logic scan_end;
      logic out_free;
   } dp_status_type;

endpackage

[design/unique_tag_id_collector_core.sv]
// Top level of the unique tag ID collector: controller, datapath and ports.
//
// Collects unique 32-bit tag IDs in arrival order in a table of TABLE_DEPTH
// slots. A word with req_tuser low clears the table; with req_tuser high it
// offers req_tdata, which is skipped when it equals the invalid marker and the
// filter is on, reported with its slot when already held, dropped when the
// table is full and appended otherwise. Exactly one result word follows each
// request word. The table sits in a RAM with one registered read port, so an
// offered ID is compared against one stored entry per cycle, up to and
// including a match, otherwise against every stored entry; a clear or a
// skipped marker compares no entry. The result word appears in the same
// cycle as the next word can be taken, and the report is held back while the
// result register still holds an unread word. One item is worked on at a
// time, and a new word is taken while the previous result still waits in
// the output register. The user must write settings through the csr_ port
// only while no item is in flight; the block itself does not enforce this.
module unique_tag_id_collector_core #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [uic_pkg::TAG_W-1:0]           req_tdata,   // tag_id
   input  logic                                req_tuser,   // op
   input  logic                                req_tlast,   // last_in_scan
   // Response channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [uic_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // slot_index, unique_count,
                                                            // echo_id, zero padding
   output logic [uic_pkg::OUTCOME_W-1:0]       rsp_tuser,   // outcome
   output logic                                rsp_tlast,   // scan_done
   // Settings write channel.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [uic_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [uic_pkg::TAG_W-1:0]           csr_data
);

   uic_pkg::cmd_type       cmd;
   uic_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   uic_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   uic_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_op     (req_tuser),
      .req_tag_id (req_tdata),
      .req_last   (req_tlast),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[design/uic_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module uic_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/uic_ctrl.sv]
// Sequencing state machine for the unique tag ID collector.
module uic_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  uic_pkg::dp_status_type status,
   output uic_pkg::cmd_type       cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REPORT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      cmd      = uic_pkg::CMD_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && ready_ff) begin
               cmd      = uic_pkg::CMD_LOAD;
               ready_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd = uic_pkg::CMD_SCAN;
            if (status.skip_scan || status.hit || status.scan_end) begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            // Hold the finished word back until the result register is free.
            if (status.out_free) begin
               cmd      = uic_pkg::CMD_FINISH;
               ready_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_tready = ready_ff;

endmodule

[design/uic_datapath.sv]
// Datapath: settings registers, ID table, sequential search and result register.
module uic_datapath #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  uic_pkg::cmd_type                       cmd,
   output uic_pkg::dp_status_type                 status,
   input  logic                                   req_op,
   input  logic [uic_pkg::TAG_W-1:0]              req_tag_id,
   input  logic                                   req_last,
   input  logic                                   csr_write,
   input  logic [uic_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [uic_pkg::TAG_W-1:0]              csr_data,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [uic_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic [uic_pkg::OUTCOME_W-1:0]          rsp_tuser,
   output logic                                   rsp_tlast
);

   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int SLOT_EXT_W  = (IDX_W > uic_pkg::SLOT_W) ? IDX_W : uic_pkg::SLOT_W;
   localparam int COUNT_EXT_W = (CNT_W > uic_pkg::COUNT_W) ? CNT_W : uic_pkg::COUNT_W;

   // Settings registers.
   logic                      filter_en_ff, filter_en_in;
   logic [uic_pkg::TAG_W-1:0] marker_ff, marker_in;

   // Captured item.
   logic                      op_ff;
   logic [uic_pkg::TAG_W-1:0] id_ff;
   logic                      last_ff;

   // Search state.
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic             rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0] pend_slot_ff;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_slot_ff, hit_slot_in;

   // Result register.
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [uic_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [uic_pkg::OUTCOME_W-1:0]  rsp_user_ff, rsp_user_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic                      issue;
   logic                      more;
   logic                      match;
   logic                      is_marker;
   logic                      table_full;
   logic                      finish;
   logic                      wr_en;
   logic [uic_pkg::TAG_W-1:0] rd_data;
   uic_pkg::outcome_type      outcome;
   logic [IDX_W-1:0]          slot_sel;
   logic [CNT_W-1:0]          count_after;
   logic [SLOT_EXT_W-1:0]     slot_ext;
   logic [COUNT_EXT_W-1:0]    count_ext;

   uic_ram #(
      .WIDTH (uic_pkg::TAG_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (id_ff),
      .rd_en   (issue),
      .rd_addr (rd_ptr_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      filter_en_in = filter_en_ff;
      marker_in    = marker_ff;
      if (csr_write) begin
         case (uic_pkg::csr_index_type'(csr_index))
            uic_pkg::CSR_FILTER_EN: filter_en_in = csr_data[0];
            uic_pkg::CSR_MARKER_ID: marker_in    = csr_data;
            default: ;
         endcase
      end
   end

   assign more       = rd_ptr_ff < count_ff;
   assign issue      = (cmd == uic_pkg::CMD_SCAN) && !hit_ff && more;
   assign match      = rd_pend_ff && (rd_data == id_ff);
   assign is_marker  = op_ff && filter_en_ff && (id_ff == marker_ff);
   assign table_full = count_ff == CNT_W'(TABLE_DEPTH);
   assign finish     = cmd == uic_pkg::CMD_FINISH;

   always_comb begin
      rd_ptr_in   = rd_ptr_ff;
      rd_pend_in  = issue;
      hit_in      = hit_ff;
      hit_slot_in = hit_slot_ff;
      if (cmd == uic_pkg::CMD_LOAD) begin
         rd_ptr_in  = '0;
         rd_pend_in = 1'b0;
         hit_in     = 1'b0;
      end else if (cmd == uic_pkg::CMD_SCAN) begin
         if (issue) begin
            rd_ptr_in = rd_ptr_ff + CNT_W'(1);
         end
         // The first match in table order wins; later reads still in flight are ignored.
         if (!hit_ff && match) begin
            hit_in      = 1'b1;
            hit_slot_in = pend_slot_ff;
         end
      end
   end

   always_comb begin
      outcome     = uic_pkg::OC_ADDED;
      slot_sel    = '0;
      count_after = count_ff;
      wr_en       = 1'b0;
      if (!op_ff) begin
         outcome     = uic_pkg::OC_CLEARED;
         count_after = '0;
      end else if (is_marker) begin
         outcome = uic_pkg::OC_INVALID;
      end else if (hit_ff) begin
         outcome  = uic_pkg::OC_DUPLICATE;
         slot_sel = hit_slot_ff;
      end else if (table_full) begin
         outcome = uic_pkg::OC_FULL;
      end else begin
         outcome     = uic_pkg::OC_ADDED;
         slot_sel    = count_ff[IDX_W-1:0];
         count_after = count_ff + CNT_W'(1);
         wr_en       = finish;
      end
   end

   assign slot_ext  = SLOT_EXT_W'(slot_sel);
   assign count_ext = COUNT_EXT_W'(count_after);

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if (finish) begin
         count_in     = count_after;
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{uic_pkg::RSP_PAD_W{1'b0}}, id_ff,
                         count_ext[uic_pkg::COUNT_W-1:0], slot_ext[uic_pkg::SLOT_W-1:0]};
         rsp_user_in  = outcome;
         rsp_last_in  = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_en_ff <= uic_pkg::FILTER_RESET;
         marker_ff    <= uic_pkg::MARKER_RESET;
         count_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         filter_en_ff <= filter_en_in;
         marker_ff    <= marker_in;
         count_ff     <= count_in;
         rd_pend_ff   <= rd_pend_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd == uic_pkg::CMD_LOAD) begin
         op_ff   <= req_op;
         id_ff   <= req_tag_id;
         last_ff <= req_last;
      end
      rd_ptr_ff    <= rd_ptr_in;
      pend_slot_ff <= rd_ptr_ff[IDX_W-1:0];
      hit_slot_ff  <= hit_slot_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign status.skip_scan = !op_ff || is_marker;
   assign status.hit       = hit_ff;
   assign status.scan_end  = !rd_pend_ff && !more;
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[design/uic_checker.sv]
// Port-level checks for the unique tag ID collector, bound to the top level.
module uic_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [uic_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [uic_pkg::OUTCOME_W-1:0]  rsp_tuser
);

   // A stalled result word holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response word changed while stalled");

   // Only one item is in flight, so an accepted word closes the request side.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while an item is in flight");

   // A clear reports an empty table and no slot.
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == uic_pkg::OC_CLEARED) |->
         (rsp_tdata[uic_pkg::SLOT_W-1:0] == '0) &&
         (rsp_tdata[uic_pkg::SLOT_W+uic_pkg::COUNT_W-1:uic_pkg::SLOT_W] == '0))
      else $error("clear reported a nonzero slot or count");

   // Skipped and dropped IDs carry no slot.
   a_no_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ((rsp_tuser == uic_pkg::OC_INVALID) || (rsp_tuser == uic_pkg::OC_FULL))
         |-> rsp_tdata[uic_pkg::SLOT_W-1:0] == '0)
      else $error("skipped or dropped ID reported a slot");

   // Nothing is shown on the response side straight out of reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind unique_tag_id_collector_core uic_checker u_uic_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[tb/testbench.sv]
// Self-checking testbench for the unique tag ID collector core.
`timescale 1ns / 1ps

module testbench;

   localparam int DEPTH       = 64;
   localparam int WORD_TARGET = 1050;
   localparam int STALL_LIMIT = 3000;
   localparam int END_PAUSE   = 100;
   localparam int SHOW_LIMIT  = 10;

   typedef enum logic [1:0] {
      ENTRY_WORD,
      ENTRY_CSR,
      ENTRY_PAUSE
   } entry_kind_type;

   typedef struct {
      entry_kind_type         kind;
      logic                   op;
      logic [31:0]            tag;
      logic                   last;
      uic_pkg::csr_index_type index;
      logic [31:0]            data;
   } pending_entry_type;

   typedef struct packed {
      uic_pkg::outcome_type        outcome;
      logic [uic_pkg::SLOT_W-1:0]  slot;
      logic [uic_pkg::COUNT_W-1:0] count;
      logic [uic_pkg::TAG_W-1:0]   echo;
      logic                        done;
   } tag_result_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [uic_pkg::TAG_W-1:0]      req_tdata = '0;
   logic                           req_tuser = 1'b0;
   logic                           req_tlast = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [uic_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [uic_pkg::OUTCOME_W-1:0]  rsp_tuser;
   logic                           rsp_tlast;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   uic_pkg::csr_index_type         csr_index = uic_pkg::CSR_FILTER_EN;
   logic [uic_pkg::TAG_W-1:0]      csr_data = '0;

   // Handshakes seen at the last rising edge, read by the drivers at the falling edge.
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   logic csr_taken = 1'b0;

   pending_entry_type pending[$];
   tag_result_type    expected_results[$];
   int                word_total = 0;

   // Shadow of the collector's settings and table.
   logic                      filter_on = uic_pkg::FILTER_RESET;
   logic [uic_pkg::TAG_W-1:0] marker_id = uic_pkg::MARKER_RESET;
   logic [uic_pkg::TAG_W-1:0] held_ids[DEPTH];
   int                        held_count = 0;

   int fail_count = 0;
   int idle_cycles = 0;
   int csr_writes = 0;
   int outcome_seen[5] = '{default: 0};
   int send_gap = 0;
   int send_calm = 0;
   int recv_wait = 0;
   int recv_calm = 0;

   unique_tag_id_collector_core #(
      .TABLE_DEPTH(DEPTH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly random idle waits, with occasional runs of back-to-back words.
   function automatic int draw_idle(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         calm_left = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 16);
   endfunction

   function automatic tag_result_type predict_tag_result(input logic op,
                                                         input logic [uic_pkg::TAG_W-1:0] tag,
                                                         input logic last);
      tag_result_type r;
      bit             found;
      found     = 1'b0;
      r.outcome = uic_pkg::OC_ADDED;
      r.slot    = '0;
      r.echo    = tag;
      r.done    = last;
      if (!op) begin
         held_count = 0;
         r.outcome  = uic_pkg::OC_CLEARED;
      end else if (filter_on && tag == marker_id) begin
         r.outcome = uic_pkg::OC_INVALID;
      end else begin
         for (int k = 0; k < held_count; k++) begin
            if (!found && held_ids[k] == tag) begin
               found  = 1'b1;
               r.slot = uic_pkg::SLOT_W'(k);
            end
         end
         if (found) begin
            r.outcome = uic_pkg::OC_DUPLICATE;
         end else if (held_count >= DEPTH) begin
            r.outcome = uic_pkg::OC_FULL;
         end else begin
            r.slot               = uic_pkg::SLOT_W'(held_count);
            held_ids[held_count] = tag;
            held_count++;
         end
      end
      r.count = uic_pkg::COUNT_W'(held_count);
      return r;
   endfunction

   task automatic queue_word(input logic op, input logic [31:0] tag, input logic last);
      pending_entry_type e;
      e.kind  = ENTRY_WORD;
      e.op    = op;
      e.tag   = tag;
      e.last  = last;
      e.index = uic_pkg::CSR_FILTER_EN;
      e.data  = '0;
      pending.push_back(e);
      word_total++;
   endtask

   // A settings write is only issued once every outstanding result has been taken.
   task automatic queue_csr(input uic_pkg::csr_index_type index, input logic [31:0] data);
      pending_entry_type e;
      e.kind  = ENTRY_CSR;
      e.op    = 1'b0;
      e.tag   = '0;
      e.last  = 1'b0;
      e.index = index;
      e.data  = data;
      pending.push_back(e);
   endtask

   task automatic queue_pause();
      pending_entry_type e;
      e.kind  = ENTRY_PAUSE;
      e.op    = 1'b0;
      e.tag   = '0;
      e.last  = 1'b0;
      e.index = uic_pkg::CSR_FILTER_EN;
      e.data  = '0;
      pending.push_back(e);
   endtask

   always @(negedge clock) begin : word_driver
      pending_entry_type head;
      logic              word_hold;
      logic              csr_hold;
      word_hold = req_tvalid && !req_taken;
      csr_hold  = csr_valid && !csr_taken;
      if (!reset && !word_hold && !csr_hold) begin
         if (send_gap > 0) begin
            send_gap--;
         end else if (pending.size() > 0) begin
            head = pending[0];
            case (head.kind)
               ENTRY_WORD: begin
                  void'(pending.pop_front());
                  req_tdata <= head.tag;
                  req_tuser <= head.op;
                  req_tlast <= head.last;
                  word_hold = 1'b1;
                  send_gap  = draw_idle(send_calm);
               end
               ENTRY_CSR: begin
                  if (expected_results.size() == 0) begin
                     void'(pending.pop_front());
                     csr_index <= head.index;
                     csr_data  <= head.data;
                     csr_hold = 1'b1;
                  end
               end
               default: begin
                  if (expected_results.size() == 0) void'(pending.pop_front());
               end
            endcase
         end
      end
      req_tvalid <= word_hold;
      csr_valid  <= csr_hold;
   end

   always @(negedge clock) begin : result_pacer
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_taken) recv_wait = draw_idle(recv_calm);
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : result_checker
      tag_result_type want;
      tag_result_type got;
      if (reset) begin
         req_taken   <= 1'b0;
         rsp_taken   <= 1'b0;
         csr_taken   <= 1'b0;
         idle_cycles = 0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         rsp_taken <= rsp_tvalid && rsp_tready;
         csr_taken <= csr_valid && csr_ready;
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               uic_pkg::CSR_FILTER_EN: filter_on = csr_data[0];
               uic_pkg::CSR_MARKER_ID: marker_id = csr_data;
               default: ;
            endcase
            csr_writes++;
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(predict_tag_result(req_tuser, req_tdata, req_tlast));
         if (rsp_tvalid && rsp_tready) begin
            got.outcome = uic_pkg::outcome_type'(rsp_tuser);
            got.slot    = rsp_tdata[uic_pkg::SLOT_W-1:0];
            got.count   = rsp_tdata[uic_pkg::SLOT_W +: uic_pkg::COUNT_W];
            got.echo    = rsp_tdata[uic_pkg::SLOT_W+uic_pkg::COUNT_W +: uic_pkg::TAG_W];
            got.done    = rsp_tlast;
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= SHOW_LIMIT)
                  $display("%0t: result word with nothing outstanding, outcome %0d id %h",
                           $realtime, got.outcome, got.echo);
            end else begin
               want = expected_results.pop_front();
               outcome_seen[int'(want.outcome)]++;
               if (got.outcome !== want.outcome || got.slot !== want.slot
                   || got.count !== want.count || got.echo !== want.echo
                   || got.done !== want.done) begin
                  fail_count++;
                  if (fail_count <= SHOW_LIMIT) begin
                     $display("%0t: mismatch, expected outcome %0d slot %0d count %0d id %h done %b",
                              $realtime, want.outcome, want.slot, want.count, want.echo,
                              want.done);
                     $display("%0t:           got outcome %0d slot %0d count %0d id %h done %b",
                              $realtime, got.outcome, got.slot, got.count, got.echo,
                              got.done);
                  end
               end
            end
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $realtime, idle_cycles);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [31:0] pool[$];
      logic [31:0] id;
      logic [31:0] cur_marker;
      logic        op;
      logic        last;
      int          style;
      int          n;
      int          pick;

      cur_marker = uic_pkg::MARKER_RESET;

      // Directed part: field extremes, the reset settings, the marker, duplicates,
      // clearing and the filter switched off and on with extreme markers.
      queue_word(1'b1, 32'h0000_0000, 1'b0);
      queue_word(1'b1, 32'hFFFF_FFFF, 1'b0);
      queue_word(1'b1, uic_pkg::MARKER_RESET, 1'b0);
      queue_word(1'b1, 32'h0000_0000, 1'b0);
      queue_word(1'b1, 32'hFFFF_FFFF, 1'b1);
      queue_word(1'b1, 32'hA5A5_5A5A, 1'b0);
      queue_word(1'b0, 32'h5A5A_A5A5, 1'b1);
      queue_word(1'b1, 32'hFFFF_FFFF, 1'b0);
      queue_csr(uic_pkg::CSR_FILTER_EN, 32'd0);
      queue_word(1'b1, uic_pkg::MARKER_RESET, 1'b0);
      queue_word(1'b1, uic_pkg::MARKER_RESET, 1'b1);
      queue_csr(uic_pkg::CSR_MARKER_ID, 32'hFFFF_FFFF);
      queue_csr(uic_pkg::CSR_FILTER_EN, 32'd1);
      queue_word(1'b1, 32'hFFFF_FFFF, 1'b0);
      queue_word(1'b1, 32'h0000_0000, 1'b0);
      queue_csr(uic_pkg::CSR_MARKER_ID, 32'h0000_0000);
      queue_word(1'b1, 32'h0000_0000, 1'b0);
      queue_word(1'b1, 32'h0000_0001, 1'b1);
      queue_word(1'b0, 32'hFFFF_FFFF, 1'b0);
      queue_csr(uic_pkg::CSR_MARKER_ID, uic_pkg::MARKER_RESET);

      // Random part: mostly scan lists drawn from a pool of IDs, so that duplicates,
      // merges and a full table occur, with some noise in between.
      while (word_total < WORD_TARGET) begin
         if ($urandom_range(0, 5) == 0) queue_pause();
         if ($urandom_range(0, 7) == 0) begin
            queue_csr(uic_pkg::CSR_FILTER_EN, 32'($urandom_range(0, 1)));
            case ($urandom_range(0, 4))
               0: id = 32'h0000_0000;
               1: id = 32'hFFFF_FFFF;
               2: id = uic_pkg::MARKER_RESET;
               3: id = $urandom;
               default: id = (pool.size() > 0) ? pool[0] : $urandom;
            endcase
            cur_marker = id;
            queue_csr(uic_pkg::CSR_MARKER_ID, id);
         end
         style = $urandom_range(0, 9);
         if (style == 0) begin
            n = $urandom_range(1, 20);
            for (int k = 0; k < n; k++)
               queue_word(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
         end else if (style == 1) begin
            // Fill the table to the brim, then offer more IDs than it can hold.
            pool.delete();
            queue_word(1'b0, $urandom, 1'b0);
            n = $urandom_range(DEPTH, DEPTH + 6);
            for (int k = 0; k < n; k++) begin
               id = $urandom;
               pool.push_back(id);
               queue_word(1'b1, id, 1'b0);
            end
            for (int k = 0; k < 8; k++) begin
               id = $urandom_range(0, 1) ? pool[$urandom_range(0, pool.size() - 1)] : $urandom;
               queue_word(1'b1, id, 1'(k == 7));
            end
         end else begin
            // A scan list, either fresh after a clear or merged into what is held.
            if ($urandom_range(0, 9) < 7) begin
               pool.delete();
               queue_word(1'b0, $urandom, 1'($urandom_range(0, 1)));
            end
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(41, 90) : $urandom_range(1, 40);
            for (int k = 0; k < n; k++) pool.push_back($urandom);
            n = $urandom_range(1, 60);
            for (int k = 0; k < n; k++) begin
               pick = $urandom_range(0, 99);
               if (pick < 84)
                  id = pool[$urandom_range(0, pool.size() - 1)];
               else if (pick < 90)
                  id = cur_marker;
               else if (pick < 95)
                  id = pool[$urandom_range(0, pool.size() - 1)] ^ (32'h1 << $urandom_range(0, 31));
               else
                  id = $urandom;
               op   = ($urandom_range(0, 49) == 0) ? 1'b0 : 1'b1;
               last = (k == n - 1) || ($urandom_range(0, 29) == 0);
               queue_word(op, id, last);
            end
         end
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending.size() != 0 || req_tvalid || csr_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (END_PAUSE) @(posedge clock);
      if (expected_results.size() != 0) fail_count++;

      $display("Offered %0d words and made %0d settings writes.", word_total, csr_writes);
      $display("Outcomes: %0d added, %0d duplicate, %0d marker, %0d table full, %0d cleared.",
               outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3],
               outcome_seen[4]);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d failures", fail_count);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[unique_tag_id_collector_core.f]
design/uic_pkg.sv
design/uic_ram.sv
design/uic_ctrl.sv
design/uic_datapath.sv
design/unique_tag_id_collector_core.sv
design/uic_checker.sv
tb/testbench.sv
